### src/checkpoint_reservation_participant_top_macros.svh
// Assertion helpers shared by the RTL. Clock clk, reset rst_n (active low).
`ifndef CHECKPOINT_RESERVATION_PARTICIPANT_TOP_MACROS_SVH
`define CHECKPOINT_RESERVATION_PARTICIPANT_TOP_MACROS_SVH

// Same-cycle implication.
`define CRP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crp assertion failed");

// Next-cycle implication.
`define CRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crp assertion failed");

`endif

### src/crp_pkg.sv
package crp_pkg;

    localparam int DefMaxCheckpoints = 256;

    localparam logic [2:0] CmdSetPath = 3'd0;
    localparam logic [2:0] CmdReady   = 3'd1;
    localparam logic [2:0] CmdRelease = 3'd2;
    localparam logic [2:0] CmdReached = 3'd3;
    localparam logic [2:0] CmdCancel  = 3'd4;
    localparam logic [2:0] CmdStatus  = 3'd5;
    localparam logic [2:0] CmdResend  = 3'd6;

    localparam logic [2:0] KindReservation = 3'd0;
    localparam logic [2:0] KindReady       = 3'd1;
    localparam logic [2:0] KindRelease     = 3'd2;
    localparam logic [2:0] KindReached     = 3'd3;
    localparam logic [2:0] KindCancel      = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  checkpoint;
        logic [8:0]  path_count;
        logic        moderator_has_reservation;
        logic [31:0] moderator_reservation;
        logic        moderator_has_ready;
        logic [7:0]  moderator_ready;
        logic [7:0]  moderator_reached;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] reservation;
        logic [7:0]  checkpoint;
        logic [8:0]  path_count;
        logic        last;
    } msg_t;

    function automatic msg_t make_msg(logic [2:0] kind, logic [31:0] reservation,
                                      logic [7:0] checkpoint, logic [8:0] path_count);
        msg_t m;
        m.kind        = kind;
        m.reservation = reservation;
        m.checkpoint  = checkpoint;
        m.path_count  = path_count;
        m.last        = 1'b0;
        return m;
    endfunction

endpackage

### src/crp_if.sv
interface crp_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  checkpoint;
    logic [8:0]  path_count;
    logic        moderator_has_reservation;
    logic [31:0] moderator_reservation;
    logic        moderator_has_ready;
    logic [7:0]  moderator_ready;
    logic [7:0]  moderator_reached;

    modport source (
        output valid, command, checkpoint, path_count, moderator_has_reservation,
               moderator_reservation, moderator_has_ready, moderator_ready,
               moderator_reached,
        input  ready
    );
    modport sink (
        input  valid, command, checkpoint, path_count, moderator_has_reservation,
               moderator_reservation, moderator_has_ready, moderator_ready,
               moderator_reached,
        output ready
    );
endinterface

interface crp_msg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  message_kind;
    logic [15:0] sender;
    logic [31:0] message_reservation;
    logic [7:0]  message_checkpoint;
    logic [8:0]  message_path_count;
    logic        last_of_run;

    modport source (
        output valid, message_kind, sender, message_reservation, message_checkpoint,
               message_path_count, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, message_kind, sender, message_reservation, message_checkpoint,
               message_path_count, last_of_run,
        output ready
    );
endinterface

interface crp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] participant_number;

    modport source (output valid, participant_number, input ready);
    modport sink (input valid, participant_number, output ready);
endinterface

### src/crp_cmd.sv
`include "checkpoint_reservation_participant_top_macros.svh"

module crp_cmd #(
    parameter int MAX_CHECKPOINTS = crp_pkg::DefMaxCheckpoints
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  crp_pkg::cmd_t item,
    output logic [1:0]    n,
    output crp_pkg::msg_t msg0,
    output crp_pkg::msg_t msg1
);

    logic        hold_reg,    hold_next;
    logic [31:0] res_reg,     res_next;
    logic        rv_reg,      rv_next;
    logic [7:0]  lready_reg,  lready_next;
    logic [7:0]  lreach_reg,  lreach_next;
    logic [8:0]  spc_reg,     spc_next;

    logic [8:0]  pc_clamped;
    logic [7:0]  ready_clamp;
    logic [7:0]  ready_cp;
    logic        a_en, b_en;
    crp_pkg::msg_t a_msg, b_msg;

    always_comb
    begin
        if (item.path_count < 9'd2)
            pc_clamped = 9'd2;
        else if ({23'd0, item.path_count} > 32'(MAX_CHECKPOINTS))
            pc_clamped = 9'(MAX_CHECKPOINTS);
        else
            pc_clamped = item.path_count;
    end

    assign ready_clamp = (spc_reg >= 9'd2) ? 8'(spc_reg - 9'd2) : 8'd0;
    assign ready_cp    = (({2'd0, item.checkpoint} + 10'd1) >= {1'b0, spc_reg})
                         ? ready_clamp : item.checkpoint;

    always_comb
    begin
        hold_next   = hold_reg;
        res_next    = res_reg;
        rv_next     = rv_reg;
        lready_next = lready_reg;
        lreach_next = lreach_reg;
        spc_next    = spc_reg;
        a_en        = 1'b0;
        b_en        = 1'b0;
        a_msg       = '0;
        b_msg       = '0;
        case (item.command)
            crp_pkg::CmdSetPath:
            begin
                spc_next    = pc_clamped;
                res_next    = hold_reg ? res_reg + 32'd1 : 32'd1;
                hold_next   = 1'b1;
                rv_next     = 1'b0;
                lreach_next = 8'd0;
                a_en        = 1'b1;
                a_msg       = crp_pkg::make_msg(crp_pkg::KindReservation, res_next, 8'd0,
                                                pc_clamped);
            end
            crp_pkg::CmdReady:
            begin
                if (hold_reg && !(rv_reg && ready_cp <= lready_reg))
                begin
                    rv_next     = 1'b1;
                    lready_next = ready_cp;
                    a_en        = 1'b1;
                    a_msg       = crp_pkg::make_msg(crp_pkg::KindReady, res_reg, ready_cp,
                                                    9'd0);
                end
            end
            crp_pkg::CmdRelease:
            begin
                if (hold_reg && rv_reg && !(lready_reg < item.checkpoint))
                begin
                    if (item.checkpoint != 8'd0)
                        lready_next = item.checkpoint - 8'd1;
                    else
                        rv_next = 1'b0;
                    a_en  = 1'b1;
                    a_msg = crp_pkg::make_msg(crp_pkg::KindRelease, res_reg,
                                              item.checkpoint, 9'd0);
                end
            end
            crp_pkg::CmdReached:
            begin
                if (hold_reg && item.checkpoint > lreach_reg)
                begin
                    lreach_next = item.checkpoint;
                    a_en        = 1'b1;
                    a_msg       = crp_pkg::make_msg(crp_pkg::KindReached, res_reg,
                                                    item.checkpoint, 9'd0);
                end
            end
            crp_pkg::CmdCancel:
            begin
                if (hold_reg)
                begin
                    hold_next = 1'b0;
                    a_en      = 1'b1;
                    a_msg     = crp_pkg::make_msg(crp_pkg::KindCancel, res_reg, 8'd0, 9'd0);
                end
            end
            crp_pkg::CmdStatus:
            begin
                if (!hold_reg)
                begin
                    a_en  = item.moderator_has_reservation;
                    a_msg = crp_pkg::make_msg(crp_pkg::KindCancel,
                                              item.moderator_reservation, 8'd0, 9'd0);
                end
                else if (!item.moderator_has_reservation
                         || item.moderator_reservation != res_reg)
                begin
                    a_en  = 1'b1;
                    a_msg = crp_pkg::make_msg(crp_pkg::KindReservation, res_reg, 8'd0,
                                              spc_reg);
                    b_en  = rv_reg;
                    b_msg = crp_pkg::make_msg(crp_pkg::KindReady, res_reg, lready_reg, 9'd0);
                end
                else
                begin
                    if (item.moderator_has_ready != rv_reg
                        || (item.moderator_has_ready && item.moderator_ready != lready_reg))
                    begin
                        a_en = 1'b1;
                        if (item.moderator_has_ready && !rv_reg)
                            a_msg = crp_pkg::make_msg(crp_pkg::KindRelease, res_reg, 8'd0,
                                                      9'd0);
                        else if (item.moderator_has_ready
                                 && item.moderator_ready > lready_reg)
                            a_msg = crp_pkg::make_msg(crp_pkg::KindRelease, res_reg,
                                                      lready_reg + 8'd1, 9'd0);
                        else
                            a_msg = crp_pkg::make_msg(crp_pkg::KindReady, res_reg,
                                                      lready_reg, 9'd0);
                    end
                    b_en  = (item.moderator_reached != lreach_reg);
                    b_msg = crp_pkg::make_msg(crp_pkg::KindReached, res_reg, lreach_reg,
                                              9'd0);
                end
            end
            crp_pkg::CmdResend:
            begin
                if (hold_reg)
                begin
                    a_en  = 1'b1;
                    a_msg = crp_pkg::make_msg(crp_pkg::KindReservation, res_reg, 8'd0,
                                              spc_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // pack the two optional messages to the front
    always_comb
    begin
        n    = {1'b0, a_en} + {1'b0, b_en};
        msg0 = a_en ? a_msg : b_msg;
        msg1 = b_msg;
        msg0.last = !(a_en && b_en);
        msg1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            res_reg    <= 32'd0;
            rv_reg     <= 1'b0;
            lready_reg <= 8'd0;
            lreach_reg <= 8'd0;
            spc_reg    <= 9'd0;
        end
        else if (fire)
        begin
            hold_reg   <= hold_next;
            res_reg    <= res_next;
            rv_reg     <= rv_next;
            lready_reg <= lready_next;
            lreach_reg <= lreach_next;
            spc_reg    <= spc_next;
        end
    end

    `CRP_ASSERT_NEXT(a_set_path_holds, fire && item.command == crp_pkg::CmdSetPath, hold_reg)
    `CRP_ASSERT_IMPL(a_pair_only_status, fire && n == 2'd2, item.command == crp_pkg::CmdStatus)
    `CRP_ASSERT_NEXT(a_res_stable_quiet, fire && n == 2'd0, $stable(res_reg))

endmodule

### src/checkpoint_reservation_participant_top.sv
// Checkpoint reservation participant. A command beat is registered, decoded
// against the held reservation state, and its messages are loaded into a
// two-entry result buffer that drives the msg port. The accepted beat is held
// in in_reg until it is decoded, which waits until the buffer has room, and
// the first message of a command is offered from the buffer's head slot.
// Commands that cause zero or one message are taken one per cycle while msg
// is not stalled; a status check that answers with two messages occupies the
// single msg port until both have left, so the next command is decoded only
// on the edge at which the second of those messages leaves.
// cfg carries participant_number, which is always accepted and is stamped
// into the sender field of every message.
`include "checkpoint_reservation_participant_top_macros.svh"

module checkpoint_reservation_participant_top #(
    parameter int MAX_CHECKPOINTS = crp_pkg::DefMaxCheckpoints
) (
    input  logic      clk,
    input  logic      rst_n,
    crp_cmd_if.sink   cmd,
    crp_msg_if.source msg,
    crp_cfg_if.sink   cfg
);

    logic          in_valid_reg;
    crp_pkg::cmd_t in_reg;
    logic [15:0]   participant_number_reg;
    logic [1:0]    cnt_reg;
    crp_pkg::msg_t slot0_reg, slot1_reg;

    logic          fire;
    logic          pop;
    logic [1:0]    n;
    crp_pkg::msg_t msg0, msg1;

    assign pop       = msg.valid && msg.ready;
    assign fire      = in_valid_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop));
    assign cmd.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    crp_cmd #(
        .MAX_CHECKPOINTS (MAX_CHECKPOINTS)
    ) u_cmd (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .n     (n),
        .msg0  (msg0),
        .msg1  (msg1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            cnt_reg                <= 2'd0;
            participant_number_reg <= 16'd0;
        end
        else
        begin
            if (cmd.ready)
                in_valid_reg <= cmd.valid;
            if (fire)
                cnt_reg <= n;
            else if (pop)
                cnt_reg <= cnt_reg - 2'd1;
            if (cfg.valid)
                participant_number_reg <= cfg.participant_number;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg.command                   <= cmd.command;
            in_reg.checkpoint                <= cmd.checkpoint;
            in_reg.path_count                <= cmd.path_count;
            in_reg.moderator_has_reservation <= cmd.moderator_has_reservation;
            in_reg.moderator_reservation     <= cmd.moderator_reservation;
            in_reg.moderator_has_ready       <= cmd.moderator_has_ready;
            in_reg.moderator_ready           <= cmd.moderator_ready;
            in_reg.moderator_reached         <= cmd.moderator_reached;
        end
        if (fire)
        begin
            slot0_reg <= msg0;
            slot1_reg <= msg1;
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

    assign msg.valid               = (cnt_reg != 2'd0);
    assign msg.message_kind        = slot0_reg.kind;
    assign msg.sender              = participant_number_reg;
    assign msg.message_reservation = slot0_reg.reservation;
    assign msg.message_checkpoint  = slot0_reg.checkpoint;
    assign msg.message_path_count  = slot0_reg.path_count;
    assign msg.last_of_run         = slot0_reg.last;

    `CRP_ASSERT_IMPL(a_fire_room, fire, cnt_reg == 2'd0 || pop)
    `CRP_ASSERT_IMPL(a_pair_buffered, msg.valid && !slot0_reg.last, cnt_reg == 2'd2)
    `CRP_ASSERT_NEXT(a_cmd_kept, in_valid_reg && !fire, in_valid_reg)

endmodule
